[rtl/hmq_pkg.sv]
package hmq_pkg;

    localparam int CAPACITY = 128;

    // Slot numbers run 1..CAPACITY; memory addresses run 0..CAPACITY-1.
    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int KEY_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 8;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd1;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
    } t_out_item;

endpackage

[rtl/hmq_ram.sv]
// Simple memory: one write port and two read ports, read data registered.
module hmq_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0] o_rd_data_a,
    output logic [DATA_W-1:0] o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

[rtl/binary_min_heap_queue.sv]
// Channel  Direction  Handshake                  Beat payload
// in       input      i_in_valid / o_in_ready    i_in_data  (hmq_pkg::t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_data (hmq_pkg::t_out_item)
//
// After a beat is taken, errors, the unused selector and an insert into an empty
// queue go straight to the result; a peek first reads the root; an insert climbs
// a level per compare step; an extract moves the last entry into the root, then
// descends a level per compare step. Each result is then registered.
// Reset (synchronous, active low) empties the queue but leaves the memory as is.
// A waiting result only holds back the delivery of the next one, not its intake.
module binary_min_heap_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hmq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hmq_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_UP_CMP,
        S_DN_CMP,
        S_PLACE,
        S_FINISH
    } t_state;

    localparam int SW = hmq_pkg::SLOT_W;
    localparam int AW = hmq_pkg::ADDR_W;
    localparam int KW = hmq_pkg::KEY_W;

    t_state                  r_state, n_state;
    logic [SW-1:0]           r_count, n_count;
    logic [SW-1:0]           r_pos, n_pos;
    logic signed [KW-1:0]    r_key, n_key;
    logic [hmq_pkg::OP_W-1:0] r_op, n_op;
    logic signed [KW-1:0]    r_result, n_result;
    logic [hmq_pkg::STAT_W-1:0] r_status, n_status;
    logic                    r_out_valid, n_out_valid;
    hmq_pkg::t_out_item      r_out_data, n_out_data;

    // Memory port controls, addressed by slot number.
    logic                    wr_en;
    logic [SW-1:0]           wr_slot;
    logic signed [KW-1:0]    wr_data;
    logic [SW-1:0]           rd_slot_a, rd_slot_b;
    logic [KW-1:0]           rd_data_a, rd_data_b;

    logic signed [KW-1:0]    val_a, val_b;
    logic [SW-1:0]           parent;
    logic [SW:0]             left, right, pick, pick_dbl, count_ext;
    logic signed [KW-1:0]    pick_val;
    logic                    out_free;

    hmq_ram #(
        .DATA_W (KW),
        .DEPTH  (hmq_pkg::CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (AW'(wr_slot - SW'(1))),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (AW'(rd_slot_a - SW'(1))),
        .i_rd_addr_b (AW'(rd_slot_b - SW'(1))),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    assign val_a     = $signed(rd_data_a);
    assign val_b     = $signed(rd_data_b);
    assign parent    = r_pos >> 1;
    assign left      = {r_pos, 1'b0};
    assign right     = left + (SW + 1)'(1);
    assign count_ext = (SW + 1)'(r_count);

    // Smaller child, the left one on a tie or when the right one is absent.
    always_comb begin
        if ((right <= count_ext) && (val_b < val_a)) begin
            pick     = right;
            pick_val = val_b;
        end else begin
            pick     = left;
            pick_val = val_a;
        end
    end
    assign pick_dbl = {pick[SW-1:0], 1'b0};

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_op        = r_op;
        n_result    = r_result;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        wr_slot     = r_pos;
        wr_data     = r_key;
        rd_slot_a   = SW'(1);
        rd_slot_b   = SW'(1);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.operation;
                    n_key    = i_in_data.key_in;
                    n_result = '0;
                    n_status = hmq_pkg::ST_OK;
                    n_state  = S_FINISH;
                    if (i_in_data.operation == hmq_pkg::OP_INSERT) begin
                        if (r_count == SW'(hmq_pkg::CAPACITY)) begin
                            n_status = hmq_pkg::ST_FULL;
                        end else begin
                            n_count = r_count + SW'(1);
                            n_pos   = r_count + SW'(1);
                            if (r_count == '0) begin
                                // First key goes straight to the root.
                                wr_en   = 1'b1;
                                wr_slot = SW'(1);
                                wr_data = i_in_data.key_in;
                            end else begin
                                rd_slot_a = (r_count + SW'(1)) >> 1;
                                n_state   = S_UP_CMP;
                            end
                        end
                    end else if (i_in_data.operation == hmq_pkg::OP_PEEK ||
                                 i_in_data.operation == hmq_pkg::OP_EXTRACT) begin
                        if (r_count == '0) begin
                            n_status = hmq_pkg::ST_EMPTY;
                        end else begin
                            rd_slot_a = SW'(1);
                            rd_slot_b = r_count;
                            n_state   = S_ROOT;
                        end
                    end
                end
            end

            S_ROOT: begin
                n_result = val_a;
                n_state  = S_FINISH;
                if (r_op == hmq_pkg::OP_EXTRACT) begin
                    // The last entry moves into the hole at the root.
                    n_count = r_count - SW'(1);
                    n_key   = val_b;
                    n_pos   = SW'(1);
                    if (r_count == SW'(2)) begin
                        n_state = S_PLACE;
                    end else if (r_count > SW'(2)) begin
                        rd_slot_a = SW'(2);
                        rd_slot_b = SW'(3);
                        n_state   = S_DN_CMP;
                    end
                end
            end

            S_UP_CMP: begin
                if (r_key < val_a) begin
                    wr_en   = 1'b1;
                    wr_data = val_a;
                    n_pos   = parent;
                    if (parent == SW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        rd_slot_a = parent >> 1;
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_FINISH;
                end
            end

            S_DN_CMP: begin
                if (pick_val < r_key) begin
                    wr_en   = 1'b1;
                    wr_data = pick_val;
                    n_pos   = pick[SW-1:0];
                    if (pick_dbl > count_ext) begin
                        n_state = S_PLACE;
                    end else begin
                        rd_slot_a = pick_dbl[SW-1:0];
                        rd_slot_b = pick_dbl[SW-1:0] + SW'(1);
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_state = S_FINISH;
                end
            end

            S_PLACE: begin
                wr_en   = 1'b1;
                n_state = S_FINISH;
            end

            S_FINISH: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_data.key_out   = r_result;
                    n_out_data.status    = r_status;
                    n_out_data.occupancy = hmq_pkg::OCC_W'(r_count);
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos      <= n_pos;
        r_key      <= n_key;
        r_op       <= n_op;
        r_result   <= n_result;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
